>>> hw/rtl/lspt_pkg.sv
// ----------------------------------------------------------------------------
// Screen line position table package
// Field widths, command and index mode codes, and the word types of the
// request, result and table memory control.
// ----------------------------------------------------------------------------
package lspt_pkg;

  localparam int POS_BITS      = 48;
  localparam int LINE_W        = 8;
  localparam int CMD_W         = 3;
  localparam int IDX_IN_W      = 6;
  localparam int MODE_W        = 3;
  localparam int VIS_W         = 7;
  localparam int MAX_LINES_DEF = 64;

  localparam logic [VIS_W-1:0]    VIS_RESET = 7'd24;
  localparam logic [POS_BITS-1:0] POS_NULL  = '1;
  localparam logic [LINE_W-1:0]   LINE_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_PUSH_BOT = 3'd1,
    CMD_PUSH_TOP = 3'd2,
    CMD_READ     = 3'd3,
    CMD_FIND     = 3'd4,
    CMD_EMPTY    = 3'd5,
    CMD_FIRST    = 3'd6
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    WHERE_GIVEN   = 3'd0,
    WHERE_TOP     = 3'd1,
    WHERE_BOTTOM  = 3'd2,
    WHERE_BOTTOM1 = 3'd3,
    WHERE_MIDDLE  = 3'd4
  } where_t;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic signed [POS_BITS-1:0] file_position;
    logic [IDX_IN_W-1:0]        line_index;
    logic [IDX_IN_W-1:0]        range_end;
    logic [MODE_W-1:0]          where_mode;
  } req_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] position_out;
    logic signed [LINE_W-1:0]   line_out;
    logic                       is_empty;
    logic                       error;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } mem_op_t;

endpackage

>>> hw/rtl/lspt_mem.sv
// ----------------------------------------------------------------------------
// Line table memory
// One write port and one registered read port. Valid bits make an entry
// that was never written since reset or a clear read as null.
// ----------------------------------------------------------------------------
module lspt_mem import lspt_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF,
  parameter int IW        = $clog2(MAX_LINES),
  parameter int NW        = $clog2(MAX_LINES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  mem_op_t             op,
  input  logic [NW-1:0]       n,
  input  logic [IW-1:0]       rd_addr,
  input  logic [IW-1:0]       wr_addr,
  input  logic [POS_BITS-1:0] wr_data,
  output logic [POS_BITS-1:0] rd_data
);

  logic [POS_BITS-1:0]  mem [MAX_LINES];
  logic [MAX_LINES-1:0] valid;
  logic [POS_BITS-1:0]  rd_raw;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (op.rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (op.clr_en) begin
        for (int i = 0; i < MAX_LINES; i++) begin
          if (NW'(i) < n) begin
            valid[i] <= 1'b0;
          end
        end
      end
      if (op.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (op.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : POS_NULL;

endmodule

>>> hw/rtl/lspt_seq.sv
// ----------------------------------------------------------------------------
// Line table sequencer
// Walks the table one entry per cycle, moves entries for the scroll
// commands and builds the result word.
// ----------------------------------------------------------------------------
module lspt_seq import lspt_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF,
  parameter int IW        = $clog2(MAX_LINES),
  parameter int NW        = $clog2(MAX_LINES + 1),
  parameter int CW        = (NW > LINE_W) ? NW : LINE_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  req_t                req,
  input  logic [NW-1:0]       n,
  input  logic                take,
  output logic                idle,
  output logic                done,
  output rsp_t                res,
  output mem_op_t             op,
  output logic [IW-1:0]       rd_addr,
  output logic [IW-1:0]       wr_addr,
  output logic [POS_BITS-1:0] wr_data,
  input  logic [POS_BITS-1:0] rd_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [CMD_W-1:0]    cmd, cmd_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [IW-1:0]       addr, addr_next;
  logic [IW-1:0]       last, last_next;
  logic                down, down_next;
  logic                issuing, issuing_next;
  logic                pend, pend_next;
  logic [IW-1:0]       pidx, pidx_next;
  logic [POS_BITS-1:0] prev, prev_next;
  rsp_t                res_next;

  logic [CW-1:0] n_c, li_c, re_c, sel_k, mid_c;
  logic [IW-1:0] idx_bot, idx_bot1;
  logic          k_bad, li_bad, re_bad;
  logic          pos_lt, ent_filled, ent_blank, stop;

  assign n_c      = CW'(n);
  assign li_c     = CW'(req.line_index);
  assign re_c     = CW'(req.range_end);
  assign mid_c    = (n_c - CW'(1)) >> 1;
  assign idx_bot  = IW'(n - NW'(2));
  assign idx_bot1 = IW'(n - NW'(1));
  assign li_bad   = li_c >= n_c;
  assign re_bad   = re_c >= n_c;

  always_comb begin
    unique case (req.where_mode)
      WHERE_TOP:     sel_k = '0;
      WHERE_BOTTOM:  sel_k = n_c - CW'(2);
      WHERE_BOTTOM1: sel_k = n_c - CW'(1);
      WHERE_MIDDLE:  sel_k = mid_c;
      default:       sel_k = li_c;
    endcase
  end

  assign k_bad = sel_k >= n_c;

  assign pos_lt     = $signed(pos) < $signed(rd_data);
  assign ent_filled = rd_data != POS_NULL;
  assign ent_blank  = !ent_filled || (rd_data == '0);

  assign idle = state == S_IDLE;
  assign done = state == S_DONE;

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    pos_next     = pos;
    addr_next    = addr;
    last_next    = last;
    down_next    = down;
    issuing_next = issuing;
    pend_next    = 1'b0;
    pidx_next    = pidx;
    prev_next    = prev;
    res_next     = res;
    op           = '0;
    rd_addr      = addr;
    wr_addr      = '0;
    wr_data      = rd_data;
    stop         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next     = req.command;
          pos_next     = req.file_position;
          res_next     = '0;
          down_next    = 1'b0;
          issuing_next = 1'b1;
          addr_next    = '0;
          last_next    = idx_bot1;
          state_next   = S_SCAN;
          unique case (req.command)
            CMD_CLEAR: begin
              op.clr_en  = 1'b1;
              state_next = S_DONE;
            end
            CMD_PUSH_BOT: begin
              addr_next = IW'(1);
            end
            CMD_PUSH_TOP: begin
              addr_next = idx_bot;
              last_next = '0;
              down_next = 1'b1;
            end
            CMD_READ: begin
              if (k_bad) begin
                res_next.position_out = POS_NULL;
                res_next.error        = 1'b1;
                state_next            = S_DONE;
              end else begin
                addr_next = IW'(sel_k);
                last_next = IW'(sel_k);
              end
            end
            CMD_FIND: begin
              res_next.position_out = POS_NULL;
              res_next.line_out     = LINE_NONE;
            end
            CMD_EMPTY: begin
              if (li_bad || re_bad) begin
                res_next.error = 1'b1;
                state_next     = S_DONE;
              end else begin
                res_next.is_empty = 1'b1;
                addr_next         = IW'(li_c);
                last_next         = IW'(re_c);
                if (li_c > re_c) begin
                  state_next = S_DONE;
                end
              end
            end
            CMD_FIRST: begin
              res_next.position_out = POS_NULL;
              res_next.line_out     = LINE_NONE;
              unique case (req.where_mode)
                WHERE_TOP: begin
                  last_next = idx_bot;
                end
                WHERE_BOTTOM, WHERE_BOTTOM1: begin
                  addr_next = idx_bot;
                  last_next = '0;
                  down_next = 1'b1;
                end
                default: begin
                  if (k_bad) begin
                    res_next.error = 1'b1;
                    state_next     = S_DONE;
                  end else begin
                    addr_next = IW'(sel_k);
                    last_next = IW'(sel_k);
                  end
                end
              endcase
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issuing) begin
          op.rd_en  = 1'b1;
          pend_next = 1'b1;
          pidx_next = addr;
          if (addr == last) begin
            issuing_next = 1'b0;
          end else begin
            addr_next = down ? addr - IW'(1) : addr + IW'(1);
          end
        end
        if (pend) begin
          case (cmd)
            CMD_PUSH_BOT: begin
              op.wr_en = 1'b1;
              wr_addr  = pidx - IW'(1);
            end
            CMD_PUSH_TOP: begin
              op.wr_en = 1'b1;
              wr_addr  = pidx + IW'(1);
            end
            CMD_READ: begin
              res_next.position_out = rd_data;
            end
            CMD_FIND: begin
              prev_next = rd_data;
              if (pos_lt) begin
                stop = 1'b1;
                if (pidx != '0) begin
                  res_next.position_out = prev;
                  res_next.line_out     = LINE_W'(CW'(pidx) - CW'(1));
                end
              end
            end
            CMD_EMPTY: begin
              if (!ent_blank) begin
                res_next.is_empty = 1'b0;
                stop              = 1'b1;
              end
            end
            CMD_FIRST: begin
              if (ent_filled) begin
                res_next.position_out = rd_data;
                res_next.line_out     = LINE_W'(CW'(pidx) + CW'(1));
                stop                  = 1'b1;
              end
            end
            default: begin
              stop = 1'b1;
            end
          endcase
          if (stop) begin
            state_next = S_DONE;
          end else if (!issuing) begin
            state_next = (cmd == CMD_PUSH_BOT || cmd == CMD_PUSH_TOP) ? S_FIN : S_DONE;
          end
        end
      end

      S_FIN: begin
        op.wr_en   = 1'b1;
        wr_addr    = (cmd == CMD_PUSH_BOT) ? idx_bot1 : '0;
        wr_data    = pos;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      issuing <= issuing_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd  <= cmd_next;
    pos  <= pos_next;
    addr <= addr_next;
    last <= last_next;
    down <= down_next;
    pidx <= pidx_next;
    prev <= prev_next;
    res  <= res_next;
  end

endmodule

>>> hw/rtl/screen_line_position_table_unit.sv
// One command is taken at a time and answered with exactly one result word.
// Clear, unknown commands and out-of-range indexes finish without a scan;
// a read looks at a single entry; scroll pushes and scans step through up
// to n entries, where n is the number of lines in use, because the table
// memory has one read port and the sequencer looks at one entry per cycle.
// The result sits in an output register, so a new command can be taken
// while the previous result waits. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
// Screen line position table unit
// Top level: request and result channels, line count register, table
// memory and sequencer.
// ----------------------------------------------------------------------------
module screen_line_position_table_unit import lspt_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VIS_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_LINES);
  localparam int NW = $clog2(MAX_LINES + 1);
  localparam int CW = (NW > LINE_W) ? NW : LINE_W;

  logic [VIS_W-1:0]    visible_lines;
  logic [CW-1:0]       vis_c, n_c;
  logic [NW-1:0]       n;
  logic                start, seq_idle, seq_done, load;
  rsp_t                seq_res;
  mem_op_t             op;
  logic [IW-1:0]       rd_addr, wr_addr;
  logic [POS_BITS-1:0] wr_data, rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      visible_lines <= VIS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      visible_lines <= cfg_data;
    end
  end

  assign vis_c = CW'(visible_lines);
  assign n_c   = (vis_c < CW'(2)) ? CW'(2) :
                 (vis_c > CW'(MAX_LINES)) ? CW'(MAX_LINES) : vis_c;
  assign n     = NW'(n_c);

  assign in_ready = seq_idle;
  assign start    = in_valid && in_ready;
  assign load     = seq_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= seq_res;
    end
  end

  lspt_seq #(
    .MAX_LINES (MAX_LINES),
    .IW        (IW),
    .NW        (NW),
    .CW        (CW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (in_data),
    .n       (n),
    .take    (load),
    .idle    (seq_idle),
    .done    (seq_done),
    .res     (seq_res),
    .op      (op),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  lspt_mem #(
    .MAX_LINES (MAX_LINES),
    .IW        (IW),
    .NW        (NW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .n       (n),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("command accepted while another is in progress");

  a_done_not_idle: assert property (@(posedge clk) disable iff (rst)
    seq_done |-> !in_ready)
    else $error("sequencer idle with an undelivered result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    seq_done && out_valid && !out_ready |=> seq_done && $stable(seq_res))
    else $error("result dropped while the output word was stalled");

  a_no_clear_and_write: assert property (@(posedge clk) disable iff (rst)
    !(op.clr_en && op.wr_en))
    else $error("table clear and write in the same cycle");
`endif

endmodule
